// ----- hdl/time_of_day_seven_segment_encoder_assert.svh -----
// assertion macros shared by the time-of-day segment encoder modules
// each macro expects clk and rst (synchronous, active high) in the using module
`ifndef TIME_OF_DAY_SEVEN_SEGMENT_ENCODER_ASSERT_SVH
`define TIME_OF_DAY_SEVEN_SEGMENT_ENCODER_ASSERT_SVH

// condition holds at every edge outside reset
`define TOD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TOD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tod_seg_pkg.sv -----
// shared types, constants and the digit pattern table for the segment encoder
// no dependencies
package tod_seg_pkg;

  localparam int unsigned FRAME_LEN         = 12;
  localparam int unsigned POS_W             = 4;
  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_LEN - 1);
  localparam int unsigned FRAME_QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_DATA_W-1:0] ZONE_RESET  = 5'd9;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 5'd5;

  localparam logic [7:0] DOT_BIT    = 8'h01;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_OFFSET      = 1'b0,
    REG_LATE_NIGHT_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] seconds_count;
    logic [31:0] sub_count;
    logic        time_valid;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       segment_byte;
    logic [POS_W-1:0] digit_position;
    logic             last_byte;
  } out_item_t;

  // byte 0 of the frame sits at index 0
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_head_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pattern;
    case (digit)
      4'd0:    pattern = 8'b11111100;
      4'd1:    pattern = 8'b01100000;
      4'd2:    pattern = 8'b11011010;
      4'd3:    pattern = 8'b11110010;
      4'd4:    pattern = 8'b01100110;
      4'd5:    pattern = 8'b10110110;
      4'd6:    pattern = 8'b10111110;
      4'd7:    pattern = 8'b11100000;
      4'd8:    pattern = 8'b11111110;
      4'd9:    pattern = 8'b11110110;
      default: pattern = BLANK_BYTE;
    endcase
    return pattern;
  endfunction

endpackage

// ----- hdl/tod_seg_front.sv -----
// front end: config registers, input capture and a nine-stage pipeline that turns
// one time item into a twelve-byte segment frame; depends on tod_seg_pkg
module tod_seg_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  tod_seg_pkg::in_item_t                 item,
  input  logic                                  cfg_write,
  input  logic [tod_seg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tod_seg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  queue_full,
  output tod_seg_pkg::frame_push_t              frame_push
);
  import tod_seg_pkg::*;

  // 86400 = 675 << 7, 1e6 = 15625 << 6, 3600 = 225 << 4, 60 = 15 << 2
  localparam logic [24:0] DAY_RECIP  = 25'd25451658;  // floor(2^34 / 675)
  localparam logic [25:0] DAY_DIV    = 26'd675;
  localparam logic [26:0] MEG_RECIP  = 27'd70368744;  // floor(2^40 / 15625)
  localparam logic [26:0] MEG_DIV    = 27'd15625;
  localparam logic [8:0]  HOUR_RECIP = 9'd291;        // floor(2^16 / 225)
  localparam logic [16:0] HOUR_SEC   = 17'd3600;
  localparam logic [10:0] MIN_RECIP  = 11'd1092;      // floor(2^14 / 15)
  localparam logic [11:0] MIN_SEC    = 12'd60;
  localparam logic [20:0] DEC_RECIP  = 21'd1677721;   // floor(2^24 / 10)
  localparam logic [5:0]  HOURS_DAY  = 6'd24;
  localparam logic [5:0]  HOURS_2DAY = 6'd48;
  localparam int unsigned SUB_DIGITS = 6;

  function automatic logic [23:0] div10_wide(input logic [19:0] n);
    logic [40:0] p;
    logic [19:0] q;
    logic [19:0] r;
    p = 41'(n) * 41'(DEC_RECIP);
    q = 20'(p[40:24]);
    r = n - q * 20'd10;
    if (r >= 20'd10) begin
      q = q + 20'd1;
      r = r - 20'd10;
    end
    return {q, r[3:0]};
  endfunction

  // valid for x below 64
  function automatic logic [6:0] split10(input logic [5:0] x);
    logic [13:0] p;
    logic [2:0]  t;
    logic [5:0]  u;
    p = 14'(x) * 14'd205;
    t = p[13:11];
    u = x - 6'(t) * 6'd10;
    return {t, u[3:0]};
  endfunction

  logic [CFG_DATA_W-1:0] zone;
  logic [CFG_DATA_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone  <= ZONE_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZONE_OFFSET:      zone  <= cfg_data;
        REG_LATE_NIGHT_LIMIT: limit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       en;
  logic [9:1] v;

  assign en   = !(v[9] && queue_full);
  assign full = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[8:1], push};
    end
  end

  logic [9:1] tv;

  // stage payload
  logic [31:0] secs_s1, secs_s2;
  logic [31:0] sub_s1, sub_s2;
  logic [15:0] qd_s2;
  logic [12:0] qs_s2;
  logic [16:0] tod_s3, tod_s4;
  logic [19:0] low_s3;
  logic [4:0]  h_est_s4, h_s5;
  logic [11:0] rh_s5, rh_s6;
  logic [5:0]  hl_s6, hl_s7;
  logic [5:0]  min_est_s6, min_s7, sec_s7;
  logic [2:0]  ht_s8, mt_s8, st_s8;
  logic [3:0]  hu_s8, mu_s8, su_s8;
  logic [5:0][7:0] tbytes_s9;

  // stage combinational results
  logic [49:0] pd;
  logic [52:0] ps;
  logic [25:0] rem_d;
  logic [26:0] rem_s;
  logic [21:0] ph;
  logic [16:0] rh_raw;
  logic [4:0]  h_fix;
  logic [16:0] rh_fix;
  logic [5:0]  hsum, hwrap, hl;
  logic [20:0] pm;
  logic [11:0] rm_raw, rm_fix;
  logic [5:0]  m_fix;
  logic [6:0]  hsplit, msplit, ssplit;

  always_comb begin
    pd = 50'(secs_s1[31:7]) * 50'(DAY_RECIP);
    ps = 53'(sub_s1[31:6]) * 53'(MEG_RECIP);

    // estimates are low by at most one
    rem_d = {1'b0, secs_s2[31:7]} - 26'(qd_s2) * DAY_DIV;
    if (rem_d >= DAY_DIV) rem_d = rem_d - DAY_DIV;
    rem_s = {1'b0, sub_s2[31:6]} - 27'(qs_s2) * MEG_DIV;
    if (rem_s >= MEG_DIV) rem_s = rem_s - MEG_DIV;

    ph = 22'(tod_s3[16:4]) * 22'(HOUR_RECIP);

    rh_raw = tod_s4 - 17'(h_est_s4) * HOUR_SEC;
    h_fix  = h_est_s4;
    rh_fix = rh_raw;
    if (rh_raw >= HOUR_SEC) begin
      h_fix  = h_est_s4 + 5'd1;
      rh_fix = rh_raw - HOUR_SEC;
    end

    hsum = 6'(h_s5) + 6'(zone);
    if (hsum >= HOURS_2DAY) hwrap = hsum - HOURS_2DAY;
    else if (hsum >= HOURS_DAY) hwrap = hsum - HOURS_DAY;
    else hwrap = hsum;
    hl = (hwrap < 6'(limit)) ? hwrap + HOURS_DAY : hwrap;
    pm = 21'(rh_s5[11:2]) * 21'(MIN_RECIP);

    rm_raw = rh_s6 - 12'(min_est_s6) * MIN_SEC;
    m_fix  = min_est_s6;
    rm_fix = rm_raw;
    if (rm_raw >= MIN_SEC) begin
      m_fix  = min_est_s6 + 6'd1;
      rm_fix = rm_raw - MIN_SEC;
    end

    hsplit = split10(hl_s7);
    msplit = split10(min_s7);
    ssplit = split10(sec_s7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tv <= {tv[8:1], item.time_valid};
      // capture
      secs_s1 <= item.seconds_count;
      sub_s1  <= item.sub_count;
      // reciprocal estimates
      secs_s2 <= secs_s1;
      sub_s2  <= sub_s1;
      qd_s2   <= pd[49:34];
      qs_s2   <= ps[52:40];
      // time of day and low six sub digits
      tod_s3  <= {rem_d[9:0], secs_s2[6:0]};
      low_s3  <= {rem_s[13:0], sub_s2[5:0]};
      // hour estimate
      tod_s4   <= tod_s3;
      h_est_s4 <= ph[20:16];
      // hour and remainder within the hour
      h_s5  <= h_fix;
      rh_s5 <= rh_fix[11:0];
      // local hour and minute estimate
      hl_s6      <= hl;
      rh_s6      <= rh_s5;
      min_est_s6 <= pm[19:14];
      // minute and second
      hl_s7  <= hl_s6;
      min_s7 <= m_fix;
      sec_s7 <= rm_fix[5:0];
      // decimal digits
      ht_s8 <= hsplit[6:4];
      hu_s8 <= hsplit[3:0];
      mt_s8 <= msplit[6:4];
      mu_s8 <= msplit[3:0];
      st_s8 <= ssplit[6:4];
      su_s8 <= ssplit[3:0];
      // segment bytes, hour tens blanked when zero
      tbytes_s9[0] <= (ht_s8 == 3'd0) ? BLANK_BYTE : seg_of({1'b0, ht_s8});
      tbytes_s9[1] <= seg_of(hu_s8) | DOT_BIT;
      tbytes_s9[2] <= seg_of({1'b0, mt_s8});
      tbytes_s9[3] <= seg_of(mu_s8) | DOT_BIT;
      tbytes_s9[4] <= seg_of({1'b0, st_s8});
      tbytes_s9[5] <= seg_of(su_s8) | DOT_BIT;
    end
  end

  // sub-count digits, one decimal digit per stage from the units up (stages 4 to 9)
  logic [19:0]                dn     [0:SUB_DIGITS-2];
  logic [SUB_DIGITS-1:0][3:0] dd     [0:SUB_DIGITS-1];
  logic [19:0]                n_in   [0:SUB_DIGITS-2];
  logic [23:0]                qr     [0:SUB_DIGITS-2];
  logic [SUB_DIGITS-1:0][3:0] dd_new [0:SUB_DIGITS-1];

  always_comb begin
    n_in[0]   = low_s3;
    dd_new[0] = '0;
    for (int j = 1; j < SUB_DIGITS - 1; j++) begin
      n_in[j]   = dn[j-1];
      dd_new[j] = dd[j-1];
    end
    for (int j = 0; j < SUB_DIGITS - 1; j++) begin
      qr[j]        = div10_wide(n_in[j]);
      dd_new[j][j] = qr[j][3:0];
    end
    // what is left after five divisions is the top digit
    dd_new[SUB_DIGITS-1]               = dd[SUB_DIGITS-2];
    dd_new[SUB_DIGITS-1][SUB_DIGITS-1] = dn[SUB_DIGITS-2][3:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SUB_DIGITS - 1; j++) begin
        dn[j] <= qr[j][23:4];
      end
      for (int j = 0; j < SUB_DIGITS; j++) begin
        dd[j] <= dd_new[j];
      end
    end
  end

  always_comb begin
    frame_push.valid = v[9] && !queue_full;
    for (int k = 0; k < SUB_DIGITS; k++) begin
      frame_push.frame[k] = tv[9] ? tbytes_s9[k] : BLANK_BYTE;
      frame_push.frame[FRAME_LEN-1-k] =
        tv[9] ? seg_of(dd[SUB_DIGITS-1][k]) : BLANK_BYTE;
    end
  end

endmodule

// ----- hdl/tod_seg_fifo.sv -----
// short queue of complete frames between the front pipeline and the byte emitter
// depends on tod_seg_pkg and the assertion macro header
`include "time_of_day_seven_segment_encoder_assert.svh"

module tod_seg_fifo #(
  parameter int unsigned DEPTH = tod_seg_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tod_seg_pkg::frame_push_t  push,
  output logic                      queue_full,
  output tod_seg_pkg::frame_head_t  head,
  input  logic                      release_head
);
  import tod_seg_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t           mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (release_head) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, release_head})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign queue_full = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.frame = mem[rd_ptr];

  `TOD_ASSERT_IMPL(a_no_push_when_full, push.valid, count != CNT_W'(DEPTH), "frame pushed into full queue")
  `TOD_ASSERT_IMPL(a_no_release_when_empty, release_head, count != '0, "frame released from empty queue")

endmodule

// ----- hdl/tod_seg_back.sv -----
// back end: walks the head frame one byte per beat and frees it after the last byte
// depends on tod_seg_pkg and the assertion macro header
`include "time_of_day_seven_segment_encoder_assert.svh"

module tod_seg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  tod_seg_pkg::frame_head_t  head,
  output logic                      release_head,
  output logic                      empty,
  input  logic                      pop,
  output tod_seg_pkg::out_item_t    result
);
  import tod_seg_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             take;
  logic             at_last;

  assign empty        = !head.valid;
  assign take         = pop && head.valid;
  assign at_last      = (pos == LAST_POS);
  assign release_head = take && at_last;

  always_comb begin
    pos_next = pos;
    if (take) begin
      pos_next = at_last ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  assign result.segment_byte   = head.frame[pos];
  assign result.digit_position = pos;
  assign result.last_byte      = at_last;

  `TOD_ASSERT_HOLDS(a_pos_in_frame, pos <= LAST_POS, "byte position past end of frame")
  `TOD_ASSERT_NEXT(a_wrap_after_last, release_head, pos == '0, "position did not wrap after last byte")
  `TOD_ASSERT_IMPL(a_idle_pos_zero, !head.valid, pos == '0, "position moved with no frame queued")

endmodule

// ----- hdl/time_of_day_seven_segment_encoder.sv -----
// top level of the time-of-day seven-segment frame encoder
// depends on tod_seg_pkg, tod_seg_front, tod_seg_fifo and tod_seg_back
//
// input side is a queue write: an item (seconds, sub-count, valid flag) is taken at
// a clock edge with push high and full low. the result side is a queue read: while
// empty is low the oldest waiting segment byte is on result, and pop takes it.
// each item yields twelve bytes, positions 0 to 11, last_byte set on position 11.
// an item with time_valid low yields twelve blank bytes.
// the first byte of a frame shows once its item has passed the nine front stages
// and the frame queue. while pop stays high one byte per cycle leaves, and the byte
// emitter sets the sustained item rate. the nine-stage front pipeline and a frame
// queue of QUEUE_DEPTH entries absorb bursts of items.
// when pop stays low the queue fills, the front pipeline holds and full rises.
// config writes (zone offset, late-night limit) land on the next edge; the user is
// to make them only while no frame is in flight. the block does not enforce this.
// reset (synchronous) empties the pipeline and queue, zeroes the byte position
// and restores zone offset 9 and late-night limit 5.
module time_of_day_seven_segment_encoder #(
  parameter int unsigned QUEUE_DEPTH = tod_seg_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  tod_seg_pkg::in_item_t               item,
  output logic                                empty,
  input  logic                                pop,
  output tod_seg_pkg::out_item_t              result,
  input  logic                                cfg_write,
  input  logic [tod_seg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tod_seg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tod_seg_pkg::*;

  frame_push_t frame_push;
  frame_head_t frame_head;
  logic        queue_full;
  logic        release_head;

  tod_seg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .frame_push (frame_push)
  );

  tod_seg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (frame_push),
    .queue_full   (queue_full),
    .head         (frame_head),
    .release_head (release_head)
  );

  tod_seg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (frame_head),
    .release_head (release_head),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule
